// File: rtl/core/hashed_key_value_table_core_macros.svh
// assertion macros used by the key-value table controller
`ifndef HASHED_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define HASHED_KEY_VALUE_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HKVT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hkvt assertion failed");
`define HKVT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hkvt assertion failed");
`else
`define HKVT_ASSERT(label, prop)
`define HKVT_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/core/hkvt_pkg.sv
// shared constants, codes and controller/datapath interface types
package hkvt_pkg;
  localparam int BUCKETS_DEF      = 256;
  localparam int POOL_ENTRIES_DEF = 256;
  localparam int KEY_BYTES_DEF    = 8;
  localparam int VALUE_BYTES_DEF  = 8;

  localparam int FIELD_W = 64;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  // action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_GET   = 2'd1;
  localparam logic [1:0] ACT_ERASE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
  localparam logic [2:0] ST_FOUND       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_ERASED      = 3'd4;
  localparam logic [2:0] ST_FULL        = 3'd5;

  typedef struct packed {
    logic sweep;
    logic load;
    logic hash;
    logic head_take;
    logic node_cmp;
    logic act;
    logic alloc;
    logic deliver;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic hash_last;
    logic head_nil;
    logic key_eq;
    logic link_nil;
    logic need_alloc;
    logic out_free;
  } dp_sts_t;
endpackage

// File: rtl/core/hashed_key_value_table_core.sv
// top level of the chained hash key-value table engine
// Key-value table with chained buckets. Each input word is a put, get or
// erase (another action code is answered not found); each gives exactly
// one result word with status, value read by get and the entry count
// after the operation. After reset the block clears the bucket heads and
// loads the free-node stack, with in_ready low. An operation then runs
// FNV-1a hashing of the key (one byte per cycle through a 32-bit
// multiply), reads the bucket head (S_HEAD, S_HEADW), visits chain nodes
// (S_NRD, S_NCMP: registered reads of the node key, value and link
// memories), updates (S_ACT), allocates a node on insert (S_ALLOC) and
// loads the output register (S_FIN). in_ready rises in the same cycle as
// out_valid. One operation is worked on at a time; a finished result
// waits in the output register while the next word is accepted, and the
// load step stalls for as long as an earlier result is still waiting there.
module hashed_key_value_table_core #(
  parameter int BUCKETS      = hkvt_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = hkvt_pkg::POOL_ENTRIES_DEF,
  parameter int KEY_BYTES    = hkvt_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES  = hkvt_pkg::VALUE_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_action,
  input  logic [hkvt_pkg::FIELD_W-1:0]         in_lookup_key,
  input  logic [hkvt_pkg::FIELD_W-1:0]         in_put_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_status,
  output logic [hkvt_pkg::FIELD_W-1:0]         out_read_value,
  output logic [$clog2(POOL_ENTRIES):0]        out_entry_count
);
  hkvt_pkg::ctl_cmd_t cmd;
  hkvt_pkg::dp_sts_t  sts;

  // sequencing: init sweep, hash, chain walk, update, deliver
  hkvt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  // memories, hash unit and result register
  hkvt_dp #(
    .BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES),
    .KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_lookup_key(in_lookup_key),
    .in_put_value(in_put_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_read_value(out_read_value), .out_entry_count(out_entry_count)
  );
endmodule

// File: rtl/core/hkvt_ram.sv
// generic single write port ram with registered read
module hkvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/hkvt_dp.sv
// datapath: hash unit, table memories, chain walk registers, result register
module hkvt_dp #(
  parameter int BUCKETS      = hkvt_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = hkvt_pkg::POOL_ENTRIES_DEF,
  parameter int KEY_BYTES    = hkvt_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES  = hkvt_pkg::VALUE_BYTES_DEF,
  localparam int CW = $clog2(POOL_ENTRIES) + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hkvt_pkg::ctl_cmd_t           cmd,
  output hkvt_pkg::dp_sts_t            sts,
  input  logic [1:0]                   in_action,
  input  logic [hkvt_pkg::FIELD_W-1:0] in_lookup_key,
  input  logic [hkvt_pkg::FIELD_W-1:0] in_put_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [hkvt_pkg::FIELD_W-1:0] out_read_value,
  output logic [CW-1:0]                out_entry_count
);
  localparam int PW   = $clog2(POOL_ENTRIES);
  localparam int NW   = PW + 1;
  localparam int BW   = $clog2(BUCKETS);
  localparam int KW   = 8 * KEY_BYTES;
  localparam int VW   = 8 * VALUE_BYTES;
  localparam int HCW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int MAXD = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
  localparam int SWW  = $clog2(MAXD);
  localparam logic [NW-1:0] NIL = NW'(POOL_ENTRIES);

  logic [1:0]     act_r;
  logic [KW-1:0]  key_r;
  logic [VW-1:0]  val_r;
  logic [31:0]    h_r, h_nxt;
  logic [HCW-1:0] hcnt_r;
  logic [SWW-1:0] sweep_r;
  logic [NW-1:0]  cur_r, prev_r, head_r;
  logic           hit_r;
  logic [PW-1:0]  hit_node_r;
  logic [NW-1:0]  hit_link_r;
  logic [VW-1:0]  hit_val_r;
  logic [CW-1:0]  count_r;
  logic [2:0]     res_status_r;
  logic [VW-1:0]  res_value_r;
  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [VW-1:0]  out_value_r;
  logic [CW-1:0]  out_count_r;

  logic [BW-1:0] bucket;
  logic [7:0]    key_byte;
  logic          sweep_in_b, sweep_in_p, pool_full;

  logic          head_we;
  logic [BW-1:0] head_waddr;
  logic [NW-1:0] head_wdata, head_rdata;
  logic          key_we;
  logic [KW-1:0] key_rdata;
  logic          val_we;
  logic [PW-1:0] val_waddr;
  logic [VW-1:0] val_wdata, val_rdata;
  logic          link_we;
  logic [PW-1:0] link_waddr;
  logic [NW-1:0] link_wdata, link_rdata;
  logic          free_we;
  logic [PW-1:0] free_waddr, free_wdata, free_raddr, free_rdata;

  assign bucket     = h_r[BW-1:0];
  assign key_byte   = key_r[{hcnt_r, 3'b000} +: 8];
  assign h_nxt      = (h_r ^ {24'd0, key_byte}) * hkvt_pkg::FNV_PRIME;
  assign sweep_in_b = ({1'b0, sweep_r} < (SWW + 1)'(BUCKETS));
  assign sweep_in_p = ({1'b0, sweep_r} < (SWW + 1)'(POOL_ENTRIES));
  assign pool_full  = (count_r >= CW'(POOL_ENTRIES));
  assign free_raddr = PW'(CW'(POOL_ENTRIES - 1) - count_r);

  // status back to the controller
  always_comb begin
    sts.sweep_last = (sweep_r == SWW'(MAXD - 1));
    sts.hash_last  = (hcnt_r == HCW'(KEY_BYTES - 1));
    sts.head_nil   = (head_rdata >= NIL);
    sts.key_eq     = (key_rdata == key_r);
    sts.link_nil   = (link_rdata >= NIL);
    sts.need_alloc = (act_r == hkvt_pkg::ACT_PUT) && !hit_r && !pool_full;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // memory write ports
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = NIL;
    key_we     = cmd.alloc;
    val_we     = 1'b0;
    val_waddr  = free_rdata;
    val_wdata  = val_r;
    link_we    = 1'b0;
    link_waddr = free_rdata;
    link_wdata = head_r;
    free_we    = 1'b0;
    free_waddr = PW'(CW'(POOL_ENTRIES) - count_r);
    free_wdata = hit_node_r;
    if (cmd.sweep) begin
      head_we    = sweep_in_b;
      head_waddr = BW'(sweep_r);
      free_we    = sweep_in_p;
      free_waddr = PW'(sweep_r);
      free_wdata = PW'(sweep_r);
    end
    if (cmd.alloc) begin
      head_we    = 1'b1;
      head_wdata = NW'(free_rdata);
      val_we     = 1'b1;
      link_we    = 1'b1;
    end
    if (cmd.act && hit_r) begin
      if (act_r == hkvt_pkg::ACT_PUT) begin
        val_we    = 1'b1;
        val_waddr = hit_node_r;
      end
      if (act_r == hkvt_pkg::ACT_ERASE) begin
        free_we = 1'b1;
        if (prev_r >= NIL) begin
          head_we    = 1'b1;
          head_wdata = hit_link_r;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_r[PW-1:0];
          link_wdata = hit_link_r;
        end
      end
    end
  end

  hkvt_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(bucket), .rdata(head_rdata)
  );
  hkvt_ram #(.WIDTH(KW), .DEPTH(POOL_ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(free_rdata), .wdata(key_r),
    .raddr(cur_r[PW-1:0]), .rdata(key_rdata)
  );
  hkvt_ram #(.WIDTH(VW), .DEPTH(POOL_ENTRIES)) u_val (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(cur_r[PW-1:0]), .rdata(val_rdata)
  );
  hkvt_ram #(.WIDTH(NW), .DEPTH(POOL_ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur_r[PW-1:0]), .rdata(link_rdata)
  );
  hkvt_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_free (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(free_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      key_r  <= in_lookup_key[KW-1:0];
      val_r  <= in_put_value[VW-1:0];
      h_r    <= hkvt_pkg::FNV_OFFSET;
      hcnt_r <= '0;
    end
    if (cmd.hash) begin
      h_r    <= h_nxt;
      hcnt_r <= hcnt_r + HCW'(1);
    end
    if (cmd.head_take) begin
      head_r <= head_rdata;
      cur_r  <= head_rdata;
      prev_r <= NIL;
    end
    if (cmd.node_cmp) begin
      if (sts.key_eq) begin
        hit_node_r <= cur_r[PW-1:0];
        hit_link_r <= link_rdata;
        hit_val_r  <= val_rdata;
      end else begin
        prev_r <= cur_r;
        cur_r  <= link_rdata;
      end
    end
    if (cmd.act) begin
      // a put that inserts is answered by the allocate step
      case (act_r)
        hkvt_pkg::ACT_PUT: begin
          if (hit_r) res_status_r <= hkvt_pkg::ST_OVERWRITTEN;
          else if (pool_full) res_status_r <= hkvt_pkg::ST_FULL;
          else res_status_r <= hkvt_pkg::ST_NOT_FOUND;
        end
        hkvt_pkg::ACT_GET: begin
          res_status_r <= hit_r ? hkvt_pkg::ST_FOUND : hkvt_pkg::ST_NOT_FOUND;
        end
        hkvt_pkg::ACT_ERASE: begin
          res_status_r <= hit_r ? hkvt_pkg::ST_ERASED : hkvt_pkg::ST_NOT_FOUND;
        end
        default: res_status_r <= hkvt_pkg::ST_NOT_FOUND;
      endcase
      res_value_r <= (act_r == hkvt_pkg::ACT_GET && hit_r) ? hit_val_r : '0;
    end
    if (cmd.alloc) begin
      res_status_r <= hkvt_pkg::ST_INSERTED;
    end
    if (cmd.deliver) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_count_r  <= count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      hit_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) sweep_r <= sweep_r + SWW'(1);
      if (cmd.head_take) hit_r <= 1'b0;
      if (cmd.node_cmp && sts.key_eq) hit_r <= 1'b1;
      if (cmd.alloc) count_r <= count_r + CW'(1);
      if (cmd.act && hit_r && act_r == hkvt_pkg::ACT_ERASE) count_r <= count_r - CW'(1);
      if (cmd.deliver) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = hkvt_pkg::FIELD_W'(out_value_r);
  assign out_entry_count = out_count_r;
endmodule

// File: rtl/core/hkvt_ctrl.sv
// controller state machine sequencing hash, chain walk and table update
`include "hashed_key_value_table_core_macros.svh"
module hkvt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hkvt_pkg::dp_sts_t  sts,
  output hkvt_pkg::ctl_cmd_t cmd
);
  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_HASH  = 10'b0000000100,
    S_HEAD  = 10'b0000001000,
    S_HEADW = 10'b0000010000,
    S_NRD   = 10'b0000100000,
    S_NCMP  = 10'b0001000000,
    S_ACT   = 10'b0010000000,
    S_ALLOC = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_last) state_nxt = S_HEAD;
      end
      S_HEAD:  state_nxt = S_HEADW;
      S_HEADW: begin
        cmd.head_take = 1'b1;
        state_nxt     = sts.head_nil ? S_ACT : S_NRD;
      end
      S_NRD:   state_nxt = S_NCMP;
      S_NCMP: begin
        cmd.node_cmp = 1'b1;
        state_nxt    = (sts.key_eq || sts.link_nil) ? S_ACT : S_NRD;
      end
      S_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = sts.need_alloc ? S_ALLOC : S_FIN;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `HKVT_ASSERT(a_accept_starts_hash, in_valid && in_ready |=> state_r == S_HASH)
  `HKVT_ASSERT(a_alloc_after_act, state_r == S_ALLOC |-> $past(state_r) == S_ACT)
  `HKVT_ASSERT(a_fin_waits, state_r == S_FIN && !sts.out_free |=> state_r == S_FIN)
  `HKVT_ASSERT_ALWAYS(a_reset_to_init, !rst_n |=> state_r == S_INIT)
endmodule

// File: tb/hashed_key_value_table_core_tb.sv
// self-checking testbench for the chained hash key-value table core
`timescale 1ns / 100ps

module hashed_key_value_table_core_tb;
  localparam int NBUCKET = 256;
  localparam int NPOOL   = 256;
  localparam int NIL     = NPOOL;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
  } op_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [8:0]  entry_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [63:0] in_lookup_key = '0;
  logic [63:0] in_put_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [63:0] out_read_value;
  logic [8:0] out_entry_count;

  hashed_key_value_table_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_lookup_key(in_lookup_key), .in_put_value(in_put_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_read_value(out_read_value), .out_entry_count(out_entry_count)
  );

  always #4 clk = ~clk;

  // table shadow: bucket chains over a node pool with a free-node stack
  int          shadow_head[NBUCKET];
  logic [63:0] shadow_key[NPOOL];
  logic [63:0] shadow_val[NPOOL];
  int          shadow_link[NPOOL];
  int          shadow_free[NPOOL];
  int          shadow_count;

  op_word_t pending_ops[$];
  answer_t  expected_answers[$];
  int  sender_idle_pct = 10;
  int  receiver_idle_pct = 83;
  bit  hold_sender = 1'b0;
  bit  in_took = 1'b0;
  int  fail_count = 0;
  int  answers_seen = 0;
  int  full_seen = 0;
  int  cycle_count = 0;
  logic [63:0] key_pool[48];

  function automatic logic [7:0] fnv_bucket(input logic [63:0] k);
    logic [31:0] h;
    h = hkvt_pkg::FNV_OFFSET;
    for (int i = 0; i < 8; i++) begin
      h = h ^ {24'd0, k[8*i +: 8]};
      h = h * hkvt_pkg::FNV_PRIME;
    end
    return h[7:0];
  endfunction

  function automatic answer_t table_apply(input op_word_t w);
    answer_t a;
    int b, cur, prev, hit, n;
    a = '0;
    a.status = hkvt_pkg::ST_NOT_FOUND;
    b = fnv_bucket(w.key);
    cur = shadow_head[b];
    prev = NIL;
    hit = NIL;
    while (cur != NIL) begin
      if (shadow_key[cur] == w.key) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = shadow_link[cur];
    end
    if (w.action == hkvt_pkg::ACT_PUT) begin
      if (hit != NIL) begin
        shadow_val[hit] = w.value;
        a.status = hkvt_pkg::ST_OVERWRITTEN;
      end else if (shadow_count >= NPOOL) begin
        a.status = hkvt_pkg::ST_FULL;
      end else begin
        n = shadow_free[NPOOL - 1 - shadow_count];
        shadow_key[n] = w.key;
        shadow_val[n] = w.value;
        shadow_link[n] = shadow_head[b];
        shadow_head[b] = n;
        shadow_count++;
        a.status = hkvt_pkg::ST_INSERTED;
      end
    end else if (w.action == hkvt_pkg::ACT_GET) begin
      if (hit != NIL) begin
        a.read_value = shadow_val[hit];
        a.status = hkvt_pkg::ST_FOUND;
      end
    end else if (w.action == hkvt_pkg::ACT_ERASE) begin
      if (hit != NIL) begin
        if (prev != NIL) shadow_link[prev] = shadow_link[hit];
        else shadow_head[b] = shadow_link[hit];
        shadow_link[hit] = NIL;
        shadow_count--;
        shadow_free[NPOOL - 1 - shadow_count] = hit;
        a.status = hkvt_pkg::ST_ERASED;
      end
    end
    a.entry_count = shadow_count[8:0];
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_op(input logic [1:0] act, input logic [63:0] k, input logic [63:0] v);
    op_word_t w;
    w.action = act;
    w.key = k;
    w.value = v;
    pending_ops.push_back(w);
  endtask

  // driver: next word goes out at the falling edge once the previous is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        // previous word accepted at the last rising edge
        if (pending_ops.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          in_action <= pending_ops[0].action;
          in_lookup_key <= pending_ops[0].key;
          in_put_value <= pending_ops[0].value;
          void'(pending_ops.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_ops.size() > 0 && !hold_sender &&
                   $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_action <= pending_ops[0].action;
        in_lookup_key <= pending_ops[0].key;
        in_put_value <= pending_ops[0].value;
        void'(pending_ops.pop_front());
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // predict on acceptance, check results at the rising edge
  always @(posedge clk) begin
    op_word_t w;
    answer_t  exp_a;
    if (rst_n) begin
      in_took = in_valid && in_ready;
      if (in_valid && in_ready) begin
        w.action = in_action;
        w.key = in_lookup_key;
        w.value = in_put_value;
        expected_answers.push_back(table_apply(w));
      end
      if (out_valid && out_ready) begin
        answers_seen++;
        if (out_status == hkvt_pkg::ST_FULL) full_seen++;
        if (expected_answers.size() == 0) begin
          $error("result word with nothing expected: status %0d", out_status);
          fail_count++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (out_status !== exp_a.status) begin
            $error("status expected %0d got %0d", exp_a.status, out_status);
            fail_count++;
          end
          if (out_read_value !== exp_a.read_value) begin
            $error("read_value expected %h got %h", exp_a.read_value, out_read_value);
            fail_count++;
          end
          if (out_entry_count !== exp_a.entry_count) begin
            $error("entry_count expected %0d got %0d", exp_a.entry_count,
                   out_entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hashed_key_value_table_core verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input int n_ops);
    int r;
    logic [63:0] k;
    for (int i = 0; i < n_ops; i++) begin
      r = $urandom_range(99);
      // mostly keys from a small pool so gets and erases hit
      k = (r < 85) ? key_pool[$urandom_range(47)] : rand64();
      if (r < 3) push_op(ACT_UNUSED, k, rand64());
      else if (r < 40) push_op(hkvt_pkg::ACT_PUT, k, rand64());
      else if (r < 70) push_op(hkvt_pkg::ACT_GET, k, rand64());
      else push_op(hkvt_pkg::ACT_ERASE, k, rand64());
    end
  endtask

  initial begin
    for (int i = 0; i < NBUCKET; i++) shadow_head[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      shadow_link[i] = NIL;
      shadow_free[i] = i;
    end
    shadow_count = 0;
    for (int i = 0; i < 48; i++) key_pool[i] = rand64();
    key_pool[0] = 64'd0;
    key_pool[1] = '1;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, every action, missing keys, unassigned action
    push_op(hkvt_pkg::ACT_GET, 64'd0, 64'd0);
    push_op(hkvt_pkg::ACT_ERASE, 64'd0, 64'd0);
    push_op(hkvt_pkg::ACT_PUT, 64'd0, '1);
    push_op(hkvt_pkg::ACT_PUT, '1, 64'd0);
    push_op(hkvt_pkg::ACT_GET, 64'd0, 64'd0);
    push_op(hkvt_pkg::ACT_GET, '1, '1);
    push_op(hkvt_pkg::ACT_PUT, 64'd0, 64'h5555_aaaa_5555_aaaa);
    push_op(hkvt_pkg::ACT_GET, 64'd0, 64'd0);
    push_op(ACT_UNUSED, '1, '1);
    push_op(ACT_UNUSED, 64'd0, 64'd0);
    push_op(hkvt_pkg::ACT_ERASE, '1, 64'd0);
    push_op(hkvt_pkg::ACT_GET, '1, 64'd0);
    push_op(hkvt_pkg::ACT_ERASE, '1, 64'd0);
    push_op(hkvt_pkg::ACT_ERASE, 64'd0, 64'd0);
    wait_drained();

    // phase 1: sender rarely idle, receiver mostly stalled
    random_phase(500);
    wait_drained();

    // phase 2: fill the pool to exhaustion, then overflow and overwrite
    sender_idle_pct = 83;
    receiver_idle_pct = 10;
    for (int i = 0; i < 262; i++) push_op(hkvt_pkg::ACT_PUT, rand64(), rand64());
    push_op(hkvt_pkg::ACT_PUT, key_pool[0], rand64());
    push_op(hkvt_pkg::ACT_GET, rand64(), 64'd0);
    random_phase(300);
    wait_drained();

    // pressure: sender holds off mid-stream until every result is back
    random_phase(20);
    repeat (30) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || expected_answers.size() > 0) @(posedge clk);
    hold_sender = 1'b0;

    // phase 3: no idling on either side; drain outstanding words then random mix
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    wait_drained();
    random_phase(560);
    wait_drained();
    repeat (100) @(posedge clk);

    $display("ran %0d results through put, get, erase and unused action, %0d full answers",
             answers_seen, full_seen);
    if (fail_count == 0 && expected_answers.size() == 0)
      $display("hashed_key_value_table_core verification clean");
    else
      $display("hashed_key_value_table_core verification failed");
    $finish;
  end
endmodule
